@@ design/tss_pkg.sv @@
package tss_pkg;

   localparam int ROW_W     = 32;
   localparam int ROW_IDX_W = 5;
   localparam int VTX_W     = 5;
   localparam int VC_W      = 6;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 3;

   localparam logic            CSR_VERTEX_COUNT = 1'b0;
   localparam logic [VC_W-1:0] VC_RESET         = 6'd32;

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
   } req_word_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic             vertex_valid;
      logic             is_last;
      logic             cycle_found;
   } rsp_word_type;

endpackage

@@ design/tss_chan_if.sv @@
interface tss_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

@@ design/tss_ram.sv @@
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/topological_sort_source_removal.sv @@
// Operation: accepts n row words at one per cycle, counts the in-degrees, then
//   emits vertices by source removal (n = effective vertex count).
// A new graph is accepted only after the final result word has been issued.
//   One result word leaves per emitted vertex (at least one per graph).
// Reset: vertex_count returns to 32 and the load restarts; RAM contents are kept.
module topological_sort_source_removal #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tss_pkg::ADDR_W-1:0]  paddr,
   input  logic [tss_pkg::DATA_W-1:0]  pwdata,
   output logic [tss_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   tss_chan_if.sink                    req,
   tss_chan_if.source                  rsp
);

   import tss_pkg::*;

   localparam int ROWS  = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
   localparam int IDX_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(ROWS + 1);
   localparam int DEG_W = CNT_W;

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_CNT_RD = 3'd1;
   localparam logic [2:0] S_CNT    = 3'd2;
   localparam logic [2:0] S_POP    = 3'd3;
   localparam logic [2:0] S_RM_RD  = 3'd4;
   localparam logic [2:0] S_RM     = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [VC_W-1:0]  vc_ff, vc_in;
   logic [CNT_W-1:0] rows_ff, rows_in, row_j_ff, row_j_in, col_ff, col_in;
   logic [CNT_W-1:0] wp_ff, wp_in, rp_ff, rp_in, emit_ff, emit_in;
   logic [CNT_W-1:0] n_eff, n_last, rows_inc;
   logic [IDX_W-1:0] src_ff, src_in, pend_ff, pend_in, b_idx_ff, b_idx_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             b_valid_ff, b_valid_in, b_first_ff, b_first_in;
   logic             b_last_ff, b_last_in, b_rm_ff, b_rm_in, b_hit_ff, b_hit_in;
   logic [ROWS-1:0]  mark_ff, mark_in;
   logic [IDX_W-1:0] qmem_ff [ROWS];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             adj_we, adj_re;
   logic [IDX_W-1:0] adj_wa, adj_ra;
   logic [ROW_W-1:0] adj_rdata;
   logic             deg_we, deg_re;
   logic [IDX_W-1:0] deg_wa, deg_ra;
   logic [DEG_W-1:0] deg_wd, deg_rdata, deg_new;

   logic             accept, out_free, enq, csr_wr;

   tss_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_wa),
      .wr_data (req.word.row_bits),
      .rd_en   (adj_re),
      .rd_addr (adj_ra),
      .rd_data (adj_rdata)
   );

   tss_ram #(.WIDTH(DEG_W), .DEPTH(ROWS)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_wa),
      .wr_data (deg_wd),
      .rd_en   (deg_re),
      .rd_addr (deg_ra),
      .rd_data (deg_rdata)
   );

   // effective vertex count, clamped to 1..ROWS
   always_comb begin
      if (vc_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (vc_ff > VC_W'(ROWS)) begin
         n_eff = CNT_W'(ROWS);
      end else begin
         n_eff = CNT_W'(vc_ff);
      end
   end

   assign n_last   = n_eff - CNT_W'(1);
   assign rows_inc = (rows_ff < n_eff) ? rows_ff + CNT_W'(1) : rows_ff;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == CSR_VERTEX_COUNT) ? DATA_W'(vc_ff) : '0;

   assign req.ready = (state_ff == S_LOAD);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;

   // in-degree write-back stage
   always_comb begin
      if (b_rm_ff) begin
         deg_new = (b_hit_ff && deg_rdata != '0) ? deg_rdata - DEG_W'(1) : deg_rdata;
      end else if (b_first_ff) begin
         deg_new = DEG_W'(b_hit_ff);
      end else begin
         deg_new = deg_rdata + DEG_W'(b_hit_ff);
      end
   end

   assign deg_we = b_valid_ff;
   assign deg_wa = b_idx_ff;
   assign deg_wd = deg_new;
   assign enq    = b_valid_ff && (b_rm_ff || b_last_ff) && deg_new == '0
                   && !mark_ff[b_idx_ff];

   always_comb begin
      state_in      = state_ff;
      vc_in         = vc_ff;
      rows_in       = rows_ff;
      row_j_in      = row_j_ff;
      col_in        = col_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      emit_in       = emit_ff;
      src_in        = src_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      mark_in       = mark_ff;
      b_valid_in    = 1'b0;
      b_idx_in      = col_ff[IDX_W-1:0];
      b_hit_in      = adj_rdata[ROW_IDX_W'(col_ff)];
      b_first_in    = b_first_ff;
      b_last_in     = b_last_ff;
      b_rm_in       = b_rm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_word_in   = rsp_word_ff;
      adj_we        = 1'b0;
      adj_wa        = rows_ff[IDX_W-1:0];
      adj_re        = 1'b0;
      adj_ra        = row_j_ff[IDX_W-1:0];
      deg_re        = 1'b0;
      deg_ra        = col_ff[IDX_W-1:0];

      if (csr_wr && paddr[2] == CSR_VERTEX_COUNT) begin
         vc_in = pwdata[VC_W-1:0];
      end

      if (enq) begin
         wp_in             = wp_ff + CNT_W'(1);
         mark_in[b_idx_ff] = 1'b1;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               adj_we  = (rows_ff < n_eff);
               rows_in = rows_inc;
               if (rows_inc >= n_eff) begin
                  state_in      = S_CNT_RD;
                  rows_in       = '0;
                  row_j_in      = '0;
                  wp_in         = '0;
                  rp_in         = '0;
                  emit_in       = '0;
                  mark_in       = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         S_CNT_RD: begin
            adj_re   = 1'b1;
            col_in   = '0;
            state_in = S_CNT;
         end
         S_CNT: begin
            deg_re     = 1'b1;
            b_valid_in = 1'b1;
            b_first_in = (row_j_ff == '0);
            b_last_in  = (row_j_ff == n_last);
            b_rm_in    = 1'b0;
            if (col_ff == n_last) begin
               if (row_j_ff == n_last) begin
                  state_in = S_POP;
               end else begin
                  row_j_in = row_j_ff + CNT_W'(1);
                  state_in = S_CNT_RD;
               end
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
         S_POP: begin
            // wait for the last write-back, it may still enqueue
            if (!b_valid_ff) begin
               if (rp_ff != wp_ff) begin
                  if (!pend_valid_ff || out_free) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{vertex: VTX_W'(pend_ff), vertex_valid: 1'b1,
                                         is_last: 1'b0, cycle_found: 1'b0};
                     end
                     pend_in       = qmem_ff[rp_ff[IDX_W-1:0]];
                     src_in        = qmem_ff[rp_ff[IDX_W-1:0]];
                     pend_valid_in = 1'b1;
                     rp_in         = rp_ff + CNT_W'(1);
                     emit_in       = emit_ff + CNT_W'(1);
                     state_in      = S_RM_RD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RM_RD: begin
            adj_re   = 1'b1;
            adj_ra   = src_ff;
            col_in   = '0;
            state_in = S_RM;
         end
         S_RM: begin
            deg_re     = 1'b1;
            b_valid_in = 1'b1;
            b_first_in = 1'b0;
            b_last_in  = 1'b0;
            b_rm_in    = 1'b1;
            if (col_ff == n_last) begin
               state_in = S_POP;
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '{vertex: pend_valid_ff ? VTX_W'(pend_ff) : '0,
                                 vertex_valid: pend_valid_ff, is_last: 1'b1,
                                 cycle_found: (emit_ff < n_eff)};
               pend_valid_in = 1'b0;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         vc_ff         <= VC_RESET;
         rows_ff       <= '0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         emit_ff       <= '0;
         pend_valid_ff <= 1'b0;
         b_valid_ff    <= 1'b0;
         mark_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vc_ff         <= vc_in;
         rows_ff       <= rows_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         emit_ff       <= emit_in;
         pend_valid_ff <= pend_valid_in;
         b_valid_ff    <= b_valid_in;
         mark_ff       <= mark_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_j_ff    <= row_j_in;
      col_ff      <= col_in;
      src_ff      <= src_in;
      pend_ff     <= pend_in;
      b_idx_ff    <= b_idx_in;
      b_hit_ff    <= b_hit_in;
      b_first_ff  <= b_first_in;
      b_last_ff   <= b_last_in;
      b_rm_ff     <= b_rm_in;
      rsp_word_ff <= rsp_word_in;
      if (enq) begin
         qmem_ff[wp_ff[IDX_W-1:0]] <= b_idx_ff;
      end
   end

endmodule
